// ===== rtl/core/b2b_pkg.sv =====
// ----------------------------------------------------------------------------
// b2b_pkg: shared types and constants for the blake2b hash engine
// Payload structs, configuration indexes, IV and sigma schedule.
// ----------------------------------------------------------------------------
`default_nettype none

package b2b_pkg;

    typedef struct packed {
        logic        start_req;
        logic [63:0] msg_word;
        logic [7:0]  block_bytes;
        logic        final_block;
    } b2b_in_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic        last_word;
    } b2b_out_t;

    localparam logic [2:0] CFG_OUT_LENGTH    = 3'd0;
    localparam logic [2:0] CFG_KEY_LENGTH    = 3'd1;
    localparam logic [2:0] CFG_SALT_LOW      = 3'd2;
    localparam logic [2:0] CFG_SALT_HIGH     = 3'd3;
    localparam logic [2:0] CFG_PERSONAL_LOW  = 3'd4;
    localparam logic [2:0] CFG_PERSONAL_HIGH = 3'd5;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_INIT,
        ST_MIX,
        ST_EMIT
    } b2b_state_t;

    localparam logic [63:0] IV_TAB [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
        64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
        64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    localparam logic [3:0] SIGMA_TAB [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

endpackage

`default_nettype wire

// ===== rtl/core/blake2b_hash_engine.sv =====
// ----------------------------------------------------------------------------
// blake2b_hash_engine: iterative BLAKE2b compression core
// Takes message words, compresses each 128-byte block with one shared G unit
// stepped by a small sequencer, and emits the digest words after the final block.
// ----------------------------------------------------------------------------
//  channel | ports          | payload      | notes
//  s_      | s_valid/ready  | b2b_in_t     | one message word per transfer
//  m_      | m_valid/ready  | b2b_out_t    | up to eight digest words
//  cfg     | cfg_we         | cfg_wdata    | index cfg_index, no wait
//
// a word that does not close a block is stored and the engine stays in ST_LOAD
// a closing word goes through ST_INIT, then ST_MIX: twelve rounds by default,
// sixteen half-G steps per round, one shared unit (3 64-bit adds, 2 xor, 2 rotate)
// after a final block the digest words follow, one per cycle while m_ready
// no input is taken during compression or while digest words are pending
// reset clears the sequencer, word position and counter; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module blake2b_hash_engine #(
    parameter int ROUNDS = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire b2b_pkg::b2b_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output b2b_pkg::b2b_out_t      m_data,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [63:0]       cfg_wdata
);
    import b2b_pkg::*;

    localparam int RW = $clog2(ROUNDS + 1);

    logic [6:0]  out_length_reg, key_length_reg;
    logic [63:0] salt_low_reg, salt_high_reg, personal_low_reg, personal_high_reg;

    logic [63:0] chain_reg [8];
    logic [63:0] msg_reg [16];
    logic [63:0] v_reg [16];
    logic [3:0]  wpos_reg;
    logic [63:0] count_reg;
    logic        final_reg;

    b2b_state_t  state_reg, state_next;
    logic [RW-1:0] round_reg;
    logic [2:0]  gsel_reg;   // which of the eight G calls
    logic        half_reg;   // first or second half of G
    logic [2:0]  emit_reg;
    logic [3:0]  nwords;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_length_reg    <= 7'd64;
            key_length_reg    <= '0;
            salt_low_reg      <= '0;
            salt_high_reg     <= '0;
            personal_low_reg  <= '0;
            personal_high_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OUT_LENGTH:    out_length_reg    <= cfg_wdata[6:0];
                CFG_KEY_LENGTH:    key_length_reg    <= cfg_wdata[6:0];
                CFG_SALT_LOW:      salt_low_reg      <= cfg_wdata;
                CFG_SALT_HIGH:     salt_high_reg     <= cfg_wdata;
                CFG_PERSONAL_LOW:  personal_low_reg  <= cfg_wdata;
                CFG_PERSONAL_HIGH: personal_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic s_fire, m_fire, closing;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign closing = (s_data.start_req ? 4'd0 : wpos_reg) == 4'd15;

    // G operand selection
    logic [3:0] ia, ib, ic, id;
    logic [3:0] msel;
    logic [3:0] sig_row;
    always_comb begin
        ia = '0; ib = '0; ic = '0; id = '0;
        case (gsel_reg)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
    end

    // round index mod 10 for sigma row
    always_comb begin
        if (round_reg >= RW'(10)) sig_row = 4'(round_reg - RW'(10));
        else sig_row = 4'(round_reg);
    end
    assign msel = SIGMA_TAB[sig_row][{gsel_reg, half_reg}];

    // shared half-G unit
    logic [63:0] ga, gb, gc, gd, gx;
    logic [63:0] na, nb, nc, nd, t1, t2;
    assign ga = v_reg[ia];
    assign gb = v_reg[ib];
    assign gc = v_reg[ic];
    assign gd = v_reg[id];
    assign gx = msg_reg[msel];
    always_comb begin
        na = ga + gb + gx;
        t1 = gd ^ na;
        nd = half_reg ? {t1[15:0], t1[63:16]} : {t1[31:0], t1[63:32]};
        nc = gc + nd;
        t2 = gb ^ nc;
        nb = half_reg ? {t2[62:0], t2[63]} : {t2[23:0], t2[63:24]};
    end

    logic last_step;
    assign last_step = half_reg && (gsel_reg == 3'd7) && (round_reg == RW'(ROUNDS - 1));

    // parameter block and compression tweak, per word
    logic [63:0] param_word [8];
    logic [63:0] tweak_word [8];
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            param_word[i] = '0;
            tweak_word[i] = '0;
        end
        param_word[0] = {32'd0, 8'h01, 8'h01, 1'b0, key_length_reg, 1'b0, out_length_reg};
        param_word[4] = salt_low_reg;
        param_word[5] = salt_high_reg;
        param_word[6] = personal_low_reg;
        param_word[7] = personal_high_reg;
        tweak_word[4] = count_reg;
        tweak_word[6] = final_reg ? '1 : '0;
    end

    // digest length
    always_comb begin
        if (out_length_reg >= 7'd64) nwords = 4'd8;
        else nwords = 4'(({1'b0, out_length_reg} + 8'd7) >> 3);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (s_fire && closing) state_next = ST_INIT;
            ST_INIT: state_next = ST_MIX;
            ST_MIX: begin
                if (last_step) begin
                    if (final_reg && nwords != 4'd0) state_next = ST_EMIT;
                    else state_next = ST_LOAD;
                end
            end
            ST_EMIT: if (m_fire && ({1'b0, emit_reg} + 4'd1 == nwords)) state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs
    logic [63:0] dword, dmask;
    logic        dlast;
    always_comb begin
        s_ready = (state_reg == ST_LOAD);
        m_valid = (state_reg == ST_EMIT);
        dword   = chain_reg[emit_reg];
        dlast   = ({1'b0, emit_reg} + 4'd1 == nwords);
        dmask   = '1;
        if (dlast && out_length_reg < 7'd64 && out_length_reg[2:0] != 3'd0)
            dmask = (64'd1 << {out_length_reg[2:0], 3'b000}) - 64'd1;
        m_data.digest_word = dword & dmask;
        m_data.last_word   = dlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            wpos_reg  <= '0;
            count_reg <= '0;
            round_reg <= '0;
            gsel_reg  <= '0;
            half_reg  <= 1'b0;
            emit_reg  <= '0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOAD: begin
                    if (s_fire) begin
                        if (closing) begin
                            wpos_reg  <= '0;
                            count_reg <= (s_data.start_req ? 64'd0 : count_reg)
                                         + 64'(s_data.block_bytes);
                            final_reg <= s_data.final_block;
                        end else begin
                            wpos_reg <= (s_data.start_req ? 4'd0 : wpos_reg) + 4'd1;
                            if (s_data.start_req) count_reg <= '0;
                        end
                    end
                    round_reg <= '0;
                    gsel_reg  <= '0;
                    half_reg  <= 1'b0;
                    emit_reg  <= '0;
                end
                ST_MIX: begin
                    half_reg <= ~half_reg;
                    if (half_reg) begin
                        gsel_reg <= gsel_reg + 3'd1;
                        if (gsel_reg == 3'd7) round_reg <= round_reg + RW'(1);
                    end
                end
                ST_EMIT: if (m_fire) emit_reg <= emit_reg + 3'd1;
                default: ;
            endcase
        end
    end

    // datapath stores
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && s_fire) begin
            msg_reg[s_data.start_req ? 4'd0 : wpos_reg] <= s_data.msg_word;
            if (s_data.start_req) begin
                for (int i = 0; i < 8; i++) chain_reg[i] <= IV_TAB[i] ^ param_word[i];
            end
        end
        if (state_reg == ST_INIT) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i]     <= chain_reg[i];
                v_reg[i + 8] <= IV_TAB[i] ^ tweak_word[i];
            end
        end
        if (state_reg == ST_MIX) begin
            v_reg[ia] <= na;
            v_reg[ib] <= nb;
            v_reg[ic] <= nc;
            v_reg[id] <= nd;
            if (last_step) begin
                // last step result folded in directly
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= chain_reg[i]
                        ^ ((4'(i) == ia) ? na : (4'(i) == ib) ? nb : v_reg[i])
                        ^ ((4'(i + 8) == ic) ? nc : (4'(i + 8) == id) ? nd : v_reg[i + 8]);
                end
            end
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while digest pending");
    a_emit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, emit_reg} < nwords))
        else $error("digest index past length");
    a_mix_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT) |=> (state_reg == ST_MIX && round_reg == '0))
        else $error("compression did not start at round zero");

endmodule

`default_nettype wire
